// ===== hdl/adsr_envelope_generator_assert.svh =====
// Assertion macros for the ADSR envelope generator
`ifndef ADSR_ENVELOPE_GENERATOR_ASSERT_SVH
`define ADSR_ENVELOPE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define ADSR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ADSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/adsr_pkg.sv =====
// Package: widths, reset values and codes for the ADSR envelope generator
`default_nettype none

package adsr_pkg;

    localparam int LEVEL_FRAC_BITS_DEF = 23;
    localparam int FIELD_W             = 24;
    localparam int COEF_BITS           = 24;
    localparam int CFG_INDEX_W         = 2;

    localparam logic [FIELD_W-1:0] ATTACK_STEP_RST  = 24'd174763;
    localparam logic [FIELD_W-1:0] DECAY_COEF_RST   = 24'd16761127;
    localparam logic [FIELD_W-1:0] RELEASE_COEF_RST = 24'd16745054;
    localparam logic [FIELD_W-1:0] SUSTAIN_RST      = 24'd5872026;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_NOTE_ON  = 2'd1,
        CMD_NOTE_OFF = 2'd2,
        CMD_RESET    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ATTACK_STEP  = 2'd0,
        REG_DECAY_COEF   = 2'd1,
        REG_RELEASE_COEF = 2'd2,
        REG_SUSTAIN      = 2'd3
    } cfg_index_t;

    typedef enum logic [5:0] {
        ST_IDLE       = 6'b000001,
        ST_ADVANCE    = 6'b000010,
        ST_COEF_WAIT  = 6'b000100,
        ST_COEF_APPLY = 6'b001000,
        ST_VEL_WAIT   = 6'b010000,
        ST_EMIT       = 6'b100000
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/adsr_envelope_generator.sv =====
// ADSR envelope generator: command sequencer around one shared multiplier
//
//  channel   dir   handshake            payload
//  s_        in    s_valid / s_ready    s_command, s_note_velocity
//  m_        out   m_valid / m_ready    m_envelope_out, m_phase
//  cfg_      in    cfg_wr_en            cfg_wr_index, cfg_wr_data
//
// Note-on, note-off and reset are handled in the idle state.
// A tick passes advance, velocity wait and emit; in release and in decay above
// sustain the shared multiplier scales by the coefficient, then by the velocity.
// The output register lets the next transaction in while a result waits;
// a further tick stalls in the emit state until the result is taken.
// Reset (synchronous, active low) restores idle phase, zero level, full velocity.
`default_nettype none
`include "adsr_envelope_generator_assert.svh"

module adsr_envelope_generator
    import adsr_pkg::*;
#(
    parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [1:0]             s_command,
    input  wire logic [FIELD_W-1:0]     s_note_velocity,

    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [FIELD_W-1:0]          m_envelope_out,
    output logic [2:0]                  m_phase,

    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  wire logic [FIELD_W-1:0]     cfg_wr_data
);

    localparam int LEVEL_W = LEVEL_FRAC_BITS + 1;
    localparam int MB_W    = (LEVEL_W > FIELD_W) ? LEVEL_W : FIELD_W;
    localparam int PROD_W  = LEVEL_W + MB_W;
    localparam int SUM_W   = MB_W + 1;

    localparam logic [LEVEL_W-1:0] ONE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};
    localparam longint unsigned SNAP_LL =
        ((64'd1 << LEVEL_FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam logic [LEVEL_W-1:0] SNAP_THRESH = LEVEL_W'(SNAP_LL);

    state_t               state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic [LEVEL_W-1:0]   level_reg, level_next;
    logic [LEVEL_W-1:0]   velocity_reg, velocity_next;

    logic [FIELD_W-1:0]   attack_step_reg, attack_step_next;
    logic [FIELD_W-1:0]   decay_coef_reg, decay_coef_next;
    logic [FIELD_W-1:0]   release_coef_reg, release_coef_next;
    logic [FIELD_W-1:0]   sustain_reg, sustain_next;

    logic [LEVEL_W-1:0]   mul_a_reg, mul_a_next;
    logic [MB_W-1:0]      mul_b_reg, mul_b_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;

    logic [FIELD_W-1:0]   out_level_reg, out_level_next;
    phase_t               out_phase_reg, out_phase_next;
    logic                 out_valid_reg, out_valid_next;

    logic [LEVEL_W-1:0]   sus;
    logic [LEVEL_W-1:0]   vel_clamped;
    logic [SUM_W-1:0]     attack_sum;
    logic [LEVEL_W-1:0]   coef_scaled;
    logic                 load_vel;

    assign sus = (MB_W'(sustain_reg) > MB_W'(ONE)) ? ONE : LEVEL_W'(sustain_reg);
    assign vel_clamped = (MB_W'(s_note_velocity) > MB_W'(ONE)) ?
                         ONE : LEVEL_W'(s_note_velocity);
    assign attack_sum  = SUM_W'(level_reg) + SUM_W'(attack_step_reg);
    assign coef_scaled = prod_reg[COEF_BITS +: LEVEL_W];
    assign prod_next   = PROD_W'(mul_a_reg) * PROD_W'(mul_b_reg);

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = out_valid_reg;
    assign m_envelope_out = out_level_reg;
    assign m_phase        = out_phase_reg;

    always_comb begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        level_next        = level_reg;
        velocity_next     = velocity_reg;
        attack_step_next  = attack_step_reg;
        decay_coef_next   = decay_coef_reg;
        release_coef_next = release_coef_reg;
        sustain_next      = sustain_reg;
        mul_a_next        = mul_a_reg;
        mul_b_next        = mul_b_reg;
        out_level_next    = out_level_reg;
        out_phase_next    = out_phase_reg;
        out_valid_next    = out_valid_reg;
        load_vel          = 1'b0;

        if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_wr_index))
                REG_ATTACK_STEP:  attack_step_next  = cfg_wr_data;
                REG_DECAY_COEF:   decay_coef_next   = cfg_wr_data;
                REG_RELEASE_COEF: release_coef_next = cfg_wr_data;
                REG_SUSTAIN:      sustain_next      = cfg_wr_data;
            endcase
        end

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (cmd_t'(s_command))
                        CMD_TICK: begin
                            state_next = ST_ADVANCE;
                        end
                        CMD_NOTE_ON: begin
                            velocity_next = vel_clamped;
                            phase_next    = PH_ATTACK;
                        end
                        CMD_NOTE_OFF: begin
                            if (phase_reg != PH_IDLE) begin
                                phase_next = PH_RELEASE;
                            end
                        end
                        CMD_RESET: begin
                            phase_next = PH_IDLE;
                            level_next = '0;
                        end
                    endcase
                end
            end
            ST_ADVANCE: begin
                unique case (phase_reg)
                    PH_ATTACK: begin
                        if (attack_sum >= SUM_W'(ONE)) begin
                            level_next = ONE;
                            phase_next = PH_DECAY;
                        end else begin
                            level_next = LEVEL_W'(attack_sum);
                        end
                        load_vel = 1'b1;
                    end
                    PH_DECAY: begin
                        if (level_reg > sus) begin
                            mul_a_next = level_reg - sus;
                            mul_b_next = MB_W'(decay_coef_reg);
                            state_next = ST_COEF_WAIT;
                        end else begin
                            level_next = sus;
                            phase_next = PH_SUSTAIN;
                            load_vel   = 1'b1;
                        end
                    end
                    PH_SUSTAIN: begin
                        level_next = sus;
                        load_vel   = 1'b1;
                    end
                    PH_RELEASE: begin
                        mul_a_next = level_reg;
                        mul_b_next = MB_W'(release_coef_reg);
                        state_next = ST_COEF_WAIT;
                    end
                    default: begin
                        level_next = '0;
                        phase_next = PH_IDLE;
                        load_vel   = 1'b1;
                    end
                endcase
            end
            ST_COEF_WAIT: begin
                state_next = ST_COEF_APPLY;
            end
            ST_COEF_APPLY: begin
                if (phase_reg == PH_DECAY) begin
                    if (coef_scaled <= SNAP_THRESH) begin
                        level_next = sus;
                        phase_next = PH_SUSTAIN;
                    end else begin
                        level_next = sus + coef_scaled;
                    end
                end else begin
                    if (coef_scaled <= SNAP_THRESH) begin
                        level_next = '0;
                        phase_next = PH_IDLE;
                    end else begin
                        level_next = coef_scaled;
                    end
                end
                load_vel = 1'b1;
            end
            ST_VEL_WAIT: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_ready) begin
                    out_level_next = prod_reg[LEVEL_FRAC_BITS +: FIELD_W];
                    out_phase_next = phase_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_vel) begin
            mul_a_next = level_next;
            mul_b_next = MB_W'(velocity_reg);
            state_next = ST_VEL_WAIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            phase_reg        <= PH_IDLE;
            level_reg        <= '0;
            velocity_reg     <= ONE;
            attack_step_reg  <= ATTACK_STEP_RST;
            decay_coef_reg   <= DECAY_COEF_RST;
            release_coef_reg <= RELEASE_COEF_RST;
            sustain_reg      <= SUSTAIN_RST;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            level_reg        <= level_next;
            velocity_reg     <= velocity_next;
            attack_step_reg  <= attack_step_next;
            decay_coef_reg   <= decay_coef_next;
            release_coef_reg <= release_coef_next;
            sustain_reg      <= sustain_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mul_a_reg     <= mul_a_next;
        mul_b_reg     <= mul_b_next;
        prod_reg      <= prod_next;
        out_level_reg <= out_level_next;
        out_phase_reg <= out_phase_next;
    end

    // idle phase always carries a zero level
    `ADSR_ASSERT_NOW(a_idle_level_zero, aclk, aresetn,
        phase_reg == PH_IDLE, level_reg == '0, "idle phase with non-zero level")
    // an accepted tick starts the envelope step
    `ADSR_ASSERT_NEXT(a_tick_advances, aclk, aresetn,
        s_valid && s_ready && (s_command == CMD_TICK), state_reg == ST_ADVANCE,
        "tick transaction did not start a step")
    // a stalled result holds the sequencer in the emit state
    `ADSR_ASSERT_NEXT(a_emit_stall, aclk, aresetn,
        (state_reg == ST_EMIT) && out_valid_reg && !m_ready, state_reg == ST_EMIT,
        "emit left while the output register was full")
    // sustain level is tracked during every tick in the sustain phase
    `ADSR_ASSERT_NOW(a_sustain_level, aclk, aresetn,
        (state_reg == ST_VEL_WAIT) && (phase_reg == PH_SUSTAIN), level_reg == sus,
        "sustain phase level differs from sustain register")

endmodule

`default_nettype wire
